// ===== rtl/core/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Types and constants shared by the chat format code parser.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int CpWidth  = 21;
  localparam int ColWidth = 5;

  localparam logic [CpWidth-1:0] CP_COLOUR    = 21'h00003;
  localparam logic [CpWidth-1:0] CP_BOLD      = 21'h00002;
  localparam logic [CpWidth-1:0] CP_ITALIC    = 21'h0001D;
  localparam logic [CpWidth-1:0] CP_UNDERLINE = 21'h0001F;
  localparam logic [CpWidth-1:0] CP_RESET     = 21'h0000F;
  localparam logic [CpWidth-1:0] CP_COMMA     = 21'h0002C;
  localparam logic [CpWidth-1:0] CP_DIGIT_LO  = 21'h00030;
  localparam logic [CpWidth-1:0] CP_DIGIT_HI  = 21'h00039;

  localparam logic [ColWidth-1:0] COL_DEF_FG = 5'd16;
  localparam logic [ColWidth-1:0] COL_DEF_BG = 5'd17;

  typedef enum logic [5:0] {
    MODE_PLAIN = 6'b000001,
    MODE_START = 6'b000010,
    MODE_FG1   = 6'b000100,
    MODE_FG2   = 6'b001000,
    MODE_BG0   = 6'b010000,
    MODE_BG1   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               end_of_message;
  } item_t;

  typedef struct packed {
    logic [CpWidth-1:0]  text_char;
    logic [ColWidth-1:0] fg_colour;
    logic [ColWidth-1:0] bg_colour;
    logic                bold_on;
    logic                italic_on;
    logic                underline_on;
    logic                segment_start;
  } result_t;

  typedef struct packed {
    mode_t               mode;
    logic [3:0]          held_digit;
    logic [ColWidth-1:0] cur_fg;
    logic [ColWidth-1:0] cur_bg;
    logic                bold;
    logic                italic;
    logic                underline;
    logic                new_segment;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:        MODE_PLAIN,
    held_digit:  4'd0,
    cur_fg:      COL_DEF_FG,
    cur_bg:      COL_DEF_BG,
    bold:        1'b0,
    italic:      1'b0,
    underline:   1'b0,
    new_segment: 1'b1
  };

endpackage

// ===== rtl/core/ccp_step.sv =====
// ----------------------------------------------------------------------------
// ccp_step
// Parse step for one character: next parser state and the optional result.
// ----------------------------------------------------------------------------
module ccp_step import ccp_pkg::*; (
  input  state_t  state,
  input  item_t   item,
  output state_t  state_next,
  output logic    emit,
  output result_t res
);

  logic [CpWidth-1:0]  cp;
  logic                is_digit;
  logic [3:0]          d;
  logic [6:0]          two_digit;
  logic [ColWidth-1:0] col_one;
  logic [ColWidth-1:0] col_two;
  logic                do_plain;
  state_t              mid;

  assign cp        = item.code_point;
  assign is_digit  = (cp >= CP_DIGIT_LO) && (cp <= CP_DIGIT_HI);
  assign d         = cp[3:0];
  assign two_digit = {state.held_digit, 3'b000} + {2'b00, state.held_digit, 1'b0}
                   + {3'b000, d};
  assign col_one   = {1'b0, d};
  assign col_two   = (two_digit < 7'd16) ? two_digit[ColWidth-1:0] : COL_DEF_FG;

  always_comb begin
    mid      = state;
    mid.mode = MODE_PLAIN;
    do_plain = 1'b0;
    case (state.mode)
      MODE_START: begin
        if (is_digit) begin
          mid.held_digit = d;
          mid.cur_fg     = col_one;
          mid.mode       = MODE_FG1;
        end else begin
          mid.cur_fg = COL_DEF_FG;
          mid.cur_bg = COL_DEF_BG;
          do_plain   = 1'b1;
        end
      end
      MODE_FG1: begin
        if (is_digit) begin
          mid.cur_fg = col_two;
          mid.mode   = MODE_FG2;
        end else if (cp == CP_COMMA) begin
          mid.mode = MODE_BG0;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_FG2: begin
        if (cp == CP_COMMA) begin
          mid.mode = MODE_BG0;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_BG0: begin
        if (is_digit) begin
          mid.held_digit = d;
          mid.cur_bg     = col_one;
          mid.mode       = MODE_BG1;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_BG1: begin
        if (is_digit) begin
          mid.cur_bg = col_two;
        end else begin
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next        = mid;
    emit              = 1'b0;
    res.text_char     = cp;
    res.fg_colour     = mid.cur_fg;
    res.bg_colour     = mid.cur_bg;
    res.bold_on       = mid.bold;
    res.italic_on     = mid.italic;
    res.underline_on  = mid.underline;
    res.segment_start = mid.new_segment;
    if (do_plain) begin
      case (cp)
        CP_COLOUR: begin
          state_next.new_segment = 1'b1;
          state_next.mode        = MODE_START;
        end
        CP_BOLD: begin
          state_next.new_segment = 1'b1;
          state_next.bold        = ~mid.bold;
        end
        CP_ITALIC: begin
          state_next.new_segment = 1'b1;
          state_next.italic      = ~mid.italic;
        end
        CP_UNDERLINE: begin
          state_next.new_segment = 1'b1;
          state_next.underline   = ~mid.underline;
        end
        CP_RESET: begin
          state_next.new_segment = 1'b1;
          state_next.bold        = 1'b0;
          state_next.italic      = 1'b0;
          state_next.underline   = 1'b0;
          state_next.cur_fg      = COL_DEF_FG;
          state_next.cur_bg      = COL_DEF_BG;
        end
        default: begin
          emit                   = 1'b1;
          state_next.new_segment = 1'b0;
        end
      endcase
    end
    if (item.end_of_message) begin
      state_next = STATE_RESET;
    end
  end

endmodule

// ===== rtl/core/chat_format_code_parser.sv =====
// ----------------------------------------------------------------------------
// chat_format_code_parser
// Strips inline chat formatting codes and tags visible characters with style.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the output is not stalled, and the
// sustained rate is one character per cycle. Each character passes an input
// register, one parse step against the parser state, and a result register
// in that order; formatting codes produce no result. The input register can
// hold one character while a finished result waits on a stalled output. After
// the last character of a message the parser state returns to plain text with
// default colours and no style.
module chat_format_code_parser import ccp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    held_valid;
  item_t   held;
  state_t  state;
  state_t  state_next;
  logic    emit;
  result_t step_res;
  logic    out_free;
  logic    go;

  assign out_free   = !result_valid || !result_stall;
  assign go         = held_valid && out_free;
  assign item_stall = held_valid && !out_free;

  ccp_step u_step (
    .state      (state),
    .item       (held),
    .state_next (state_next),
    .emit       (emit),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= STATE_RESET;
    end else begin
      if (!item_stall) begin
        held_valid <= item_valid;
      end
      if (go) begin
        state <= state_next;
      end
      if (out_free) begin
        result_valid <= go && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
    if (go && emit) begin
      result <= step_res;
    end
  end

  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> held_valid && result_valid)
    else $error("input stalled without a held character and a waiting result");

  a_message_end_resets: assert property (@(posedge clk) disable iff (rst)
    go && held.end_of_message |=> state == STATE_RESET)
    else $error("parser state not reset after end of message");

  a_no_control_output: assert property (@(posedge clk) disable iff (rst)
    go && emit |=> result.text_char != CP_COLOUR && result.text_char != CP_BOLD
      && result.text_char != CP_ITALIC && result.text_char != CP_UNDERLINE
      && result.text_char != CP_RESET)
    else $error("formatting code emitted as text");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the chat format code parser.
// A short table of directed characters covers style toggles, colour codes,
// the comma and third-digit corners and messages that end inside a code. It
// is followed by random messages of well-formed codes, text and noise. Both
// handshakes idle at random, and every visible character is compared with its
// table entry or with a predictor of the parser state.
// ----------------------------------------------------------------------------
module tb import ccp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam int DIRECTED_LEN = 28;
  localparam int RANDOM_ITEMS = 1950;

  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{'{21'h000041, 1'b0}, 1'b1, '{21'h000041, COL_DEF_FG, COL_DEF_BG, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{21'h10FFFF, 1'b0}, 1'b1, '{21'h10FFFF, COL_DEF_FG, COL_DEF_BG, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{CP_BOLD, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_ITALIC, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_UNDERLINE, 1'b0}, 1'b0, NO_RESULT},
    '{'{21'h000000, 1'b1}, 1'b1, '{21'h000000, COL_DEF_FG, COL_DEF_BG, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{'{CP_COLOUR, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd1, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd5, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_COMMA, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd7, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd8, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_COLOUR, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd4, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_COMMA, 1'b0}, 1'b0, NO_RESULT},
    '{'{21'h00006B, 1'b1}, 1'b0, NO_RESULT},
    '{'{CP_COLOUR, 1'b0}, 1'b0, NO_RESULT},
    '{'{21'h000071, 1'b0}, 1'b1, '{21'h000071, COL_DEF_FG, COL_DEF_BG, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{CP_COLOUR, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd2, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_BOLD, 1'b0}, 1'b0, NO_RESULT},
    '{'{21'h00007A, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_COLOUR, 1'b0}, 1'b0, NO_RESULT},
    '{'{CP_DIGIT_LO + 21'd5, 1'b1}, 1'b0, NO_RESULT},
    '{'{CP_RESET, 1'b0}, 1'b0, NO_RESULT},
    '{'{21'h000077, 1'b1}, 1'b1, '{21'h000077, COL_DEF_FG, COL_DEF_BG, 1'b0, 1'b0, 1'b0, 1'b1}}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  stim_row_t stim_q [$];
  result_t   expected_chars [$];
  int        errors = 0;
  bit        no_idle = 1'b0;

  mode_t               cp_mode;
  logic [3:0]          cp_held;
  logic [ColWidth-1:0] cp_fg;
  logic [ColWidth-1:0] cp_bg;
  logic                cp_bold;
  logic                cp_italic;
  logic                cp_uline;
  logic                cp_newseg;

  chat_format_code_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic reset_parser();
    cp_mode   = MODE_PLAIN;
    cp_held   = 4'd0;
    cp_fg     = COL_DEF_FG;
    cp_bg     = COL_DEF_BG;
    cp_bold   = 1'b0;
    cp_italic = 1'b0;
    cp_uline  = 1'b0;
    cp_newseg = 1'b1;
  endtask

  function automatic logic [ColWidth-1:0] palette(input int code);
    return (code < 16) ? ColWidth'(code) : COL_DEF_FG;
  endfunction

  task automatic plain_char(input logic [CpWidth-1:0] c, output bit emits, output result_t r);
    emits = 1'b0;
    r = '0;
    case (c)
      CP_COLOUR: begin
        cp_newseg = 1'b1;
        cp_mode = MODE_START;
      end
      CP_BOLD: begin
        cp_newseg = 1'b1;
        cp_bold = ~cp_bold;
      end
      CP_ITALIC: begin
        cp_newseg = 1'b1;
        cp_italic = ~cp_italic;
      end
      CP_UNDERLINE: begin
        cp_newseg = 1'b1;
        cp_uline = ~cp_uline;
      end
      CP_RESET: begin
        cp_newseg = 1'b1;
        cp_bold = 1'b0;
        cp_italic = 1'b0;
        cp_uline = 1'b0;
        cp_fg = COL_DEF_FG;
        cp_bg = COL_DEF_BG;
      end
      default: begin
        r = '{c, cp_fg, cp_bg, cp_bold, cp_italic, cp_uline, cp_newseg};
        cp_newseg = 1'b0;
        emits = 1'b1;
      end
    endcase
  endtask

  task automatic parse_char(input item_t it, output bit emits, output result_t r);
    logic [CpWidth-1:0] c;
    logic [3:0]         d;
    bit                 dig;
    mode_t              m;
    c = it.code_point;
    dig = (c >= CP_DIGIT_LO) && (c <= CP_DIGIT_HI);
    d = 4'(c - CP_DIGIT_LO);
    m = cp_mode;
    cp_mode = MODE_PLAIN;
    emits = 1'b0;
    r = '0;
    case (m)
      MODE_START: begin
        if (dig) begin
          cp_held = d;
          cp_fg = palette(int'(d));
          cp_mode = MODE_FG1;
        end else begin
          cp_fg = COL_DEF_FG;
          cp_bg = COL_DEF_BG;
          plain_char(c, emits, r);
        end
      end
      MODE_FG1: begin
        if (dig) begin
          cp_fg = palette(int'(cp_held) * 10 + int'(d));
          cp_mode = MODE_FG2;
        end else if (c == CP_COMMA) begin
          cp_mode = MODE_BG0;
        end else begin
          plain_char(c, emits, r);
        end
      end
      MODE_FG2: begin
        if (c == CP_COMMA) begin
          cp_mode = MODE_BG0;
        end else begin
          plain_char(c, emits, r);
        end
      end
      MODE_BG0: begin
        if (dig) begin
          cp_held = d;
          cp_bg = palette(int'(d));
          cp_mode = MODE_BG1;
        end else begin
          plain_char(c, emits, r);
        end
      end
      MODE_BG1: begin
        if (dig) begin
          cp_bg = palette(int'(cp_held) * 10 + int'(d));
        end else begin
          plain_char(c, emits, r);
        end
      end
      default: plain_char(c, emits, r);
    endcase
    if (it.end_of_message) reset_parser();
  endtask

  task automatic add_cp(input logic [CpWidth-1:0] c);
    stim_row_t row;
    row = '0;
    row.it.code_point = c;
    stim_q.insert(stim_q.size(), row);
  endtask

  function automatic logic [CpWidth-1:0] rand_digit();
    return CP_DIGIT_LO + CpWidth'($urandom_range(0, 9));
  endfunction

  function automatic logic [CpWidth-1:0] rand_text();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return CpWidth'($urandom_range(32, 126));
    else if (sel < 55) return rand_digit();
    else if (sel < 60) return CP_COMMA;
    else if (sel < 80) return CpWidth'($urandom_range(0, 21'h10FFFF));
    else if (sel < 90) return CpWidth'($urandom_range(0, 31));
    else return 21'h100000 | CpWidth'($urandom_range(0, 21'hFFFF));
  endfunction

  task automatic add_colour_code();
    int nfg;
    int nbg;
    nfg = $urandom_range(0, 2);
    add_cp(CP_COLOUR);
    repeat (nfg) add_cp(rand_digit());
    if ($urandom_range(0, 2) != 0) begin
      add_cp(CP_COMMA);
      nbg = $urandom_range(0, 2);
      repeat (nbg) add_cp(rand_digit());
    end
  endtask

  task automatic add_message();
    int nseg;
    int kind;
    nseg = $urandom_range(1, 12);
    repeat (nseg) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: add_colour_code();
        3:       add_cp(CP_BOLD);
        4:       add_cp(CP_ITALIC);
        5:       add_cp(CP_UNDERLINE);
        6:       add_cp(CP_RESET);
        default: repeat ($urandom_range(1, 4)) add_cp(rand_text());
      endcase
    end
    stim_q[stim_q.size() - 1].it.end_of_message = 1'b1;
  endtask

  function automatic string fmt_char(input result_t r);
    return $sformatf("char %h fg %0d bg %0d bold %0b italic %0b uline %0b seg %0b",
                     r.text_char, r.fg_colour, r.bg_colour, r.bold_on, r.italic_on,
                     r.underline_on, r.segment_start);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : checker_blk
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_chars.size() == 0) begin
        flag_error({"unexpected transfer: ", fmt_char(result)});
      end else begin
        want = expected_chars.pop_front();
        if (result !== want) begin
          flag_error({"mismatch: expected ", fmt_char(want), " got ", fmt_char(result)});
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    hold = $urandom_range(0, 10);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
      @(posedge clk);
      if (result_valid && !result_stall) hold = no_idle ? 0 : $urandom_range(0, 10);
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : driver
    int      gap;
    bit      emits;
    result_t r;
    foreach (DIRECTED[i]) stim_q.insert(stim_q.size(), DIRECTED[i]);
    while (stim_q.size() < DIRECTED_LEN + RANDOM_ITEMS) add_message();
    reset_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (stim_q[i]) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 4) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      item <= stim_q[i].it;
      item_valid <= 1'b1;
      do @(posedge clk); while (item_stall);
      parse_char(stim_q[i].it, emits, r);
      if (stim_q[i].typed) expected_chars.insert(expected_chars.size(), stim_q[i].res);
      else if (emits) expected_chars.insert(expected_chars.size(), r);
      @(negedge clk);
    end
    item_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ccp_pkg.sv
rtl/core/ccp_step.sv
rtl/core/chat_format_code_parser.sv
verif/tb.sv
